[sv/md5_digest_engine_assert.svh]
// Assertion macros for the MD5 digest engine.
// Used by the controller and the top level; no other dependencies.
`ifndef MD5_DIGEST_ENGINE_ASSERT_SVH
`define MD5_DIGEST_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
`define MD5_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MD5_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define MD5_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define MD5_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

[sv/md5_pkg.sv]
// Shared types, constants and round functions for the MD5 digest engine.
// No dependencies.
`timescale 1ns / 1ps
package md5_pkg;

  localparam logic [1:0] REQ_DATA    = 2'd0;
  localparam logic [1:0] REQ_FINISH  = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE, ST_COMP, ST_FOLD, ST_PAD, ST_OUT
  } md5_state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic       put;       // write a byte at the current position, advance count
    logic [7:0] put_byte;
    logic       put_len;   // write length words 14/15
    logic       latch_len; // capture bit count for padding
    logic       comp_start;// load working regs from chain
    logic       round;     // execute one round
    logic       fold;      // add working regs into chain
    logic       init;      // reset chain and count
  } md5_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [5:0] pos;
    logic [5:0] round_idx;
  } md5_stat_t;

  function automatic logic [31:0] k_const(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] r;
    unique case ({i[5:4], i[1:0]})
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

endpackage

[sv/md5_ctrl.sv]
// Controller FSM for the MD5 digest engine: request decode, padding, output.
// Depends on md5_pkg and md5_digest_engine_assert.svh.
`timescale 1ns / 1ps
`include "md5_digest_engine_assert.svh"
module md5_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [1:0]         req_type,
  input  logic [7:0]         data_byte,
  input  md5_pkg::md5_stat_t stat,
  output md5_pkg::md5_cmd_t  cmd,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [1:0]         out_idx
);
  import md5_pkg::*;

  md5_state_t state_r, state_nxt;
  logic       fin_r, fin_nxt;     // compression belongs to finish padding
  logic       padded_r, padded_nxt; // 0x80 already placed
  logic [1:0] idx_r, idx_nxt;
  logic       acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_OUT);
  assign out_idx    = idx_r;

  // next state
  always_comb begin
    state_nxt  = state_r;
    fin_nxt    = fin_r;
    padded_nxt = padded_r;
    idx_nxt    = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && req_type == REQ_DATA && stat.pos == 6'd63) begin
          state_nxt = ST_COMP;
          fin_nxt   = 1'b0;
        end else if (acc && req_type == REQ_FINISH) begin
          state_nxt  = ST_PAD;
          padded_nxt = 1'b0;
        end
      end
      ST_PAD: begin
        if (padded_r && stat.pos == LEN_POS) begin
          state_nxt = ST_COMP;
          fin_nxt   = 1'b1;
        end else begin
          padded_nxt = 1'b1;
          if (stat.pos == 6'd63) begin
            state_nxt = ST_COMP;
            fin_nxt   = 1'b0;
          end
        end
      end
      ST_COMP: if (stat.round_idx == 6'd63) state_nxt = ST_FOLD;
      ST_FOLD: begin
        if (!fin_r && !padded_r) state_nxt = ST_IDLE;
        else if (!fin_r) state_nxt = ST_PAD;
        else begin
          state_nxt = ST_OUT;
          idx_nxt   = 2'd0;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            state_nxt  = ST_IDLE;
            padded_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && req_type == REQ_DATA) begin
          cmd.put = 1'b1; cmd.put_byte = data_byte;
          // last byte of a block: load working regs for compression
          if (stat.pos == 6'd63) cmd.comp_start = 1'b1;
        end
        if (acc && req_type == REQ_FINISH) cmd.latch_len = 1'b1;
        if (acc && req_type == REQ_RESTART) cmd.init = 1'b1;
      end
      ST_PAD: begin
        if (padded_r && stat.pos == LEN_POS) begin
          cmd.put_len = 1'b1;
          cmd.comp_start = 1'b1;
        end else begin
          cmd.put = 1'b1;
          cmd.put_byte = padded_r ? 8'h00 : PAD_BYTE;
          if (stat.pos == 6'd63) cmd.comp_start = 1'b1;
        end
      end
      ST_COMP: cmd.round = 1'b1;
      ST_FOLD: cmd.fold = 1'b1;
      ST_OUT:  cmd.init = out_tready && (idx_r == 2'd3);
      default: cmd = '0;
    endcase
  end

  // a data byte at position 63 also starts compression
  logic start_on_data;
  assign start_on_data = (state_r == ST_IDLE) && acc && req_type == REQ_DATA
                         && stat.pos == 6'd63;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fin_r    <= 1'b0;
      padded_r <= 1'b0;
      idx_r    <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      fin_r    <= fin_nxt;
      padded_r <= start_on_data ? 1'b0 : padded_nxt;
      idx_r    <= idx_nxt;
    end
  end

  `MD5_ASSERT_NEXT(a_comp_runs, clk, rst_n, state_r == ST_COMP && stat.round_idx != 6'd63,
    state_r == ST_COMP, "compression left early")
  `MD5_ASSERT_NEXT(a_fold_after, clk, rst_n, state_r == ST_COMP && stat.round_idx == 6'd63,
    state_r == ST_FOLD, "fold did not follow last round")
  `MD5_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, (state_r != ST_IDLE) |-> !in_tready,
    "input accepted while busy")
endmodule

[sv/md5_dp.sv]
// Datapath of the MD5 digest engine: block buffer, bit count, chain and round unit.
// Depends on md5_pkg.
`timescale 1ns / 1ps
module md5_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  md5_pkg::md5_cmd_t  cmd,
  input  logic [1:0]         out_idx,
  output md5_pkg::md5_stat_t stat,
  output logic [31:0]        digest_word
);
  import md5_pkg::*;

  logic [31:0] buf_r [16];
  logic [63:0] cnt_r, cnt_nxt;
  logic [63:0] len_r;
  logic [31:0] ch_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [5:0]  rnd_r;
  logic [5:0]  pos;

  assign pos = cnt_r[8:3];
  assign stat.pos = pos;
  assign stat.round_idx = rnd_r;
  assign digest_word = ch_r[out_idx];

  // bit count and padding length
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.put) cnt_nxt = cnt_r + 64'd8;
    if (cmd.init) cnt_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_len) len_r <= cnt_r;
  end

  // block buffer byte and length writes
  always_ff @(posedge clk) begin
    if (cmd.put) buf_r[pos[5:2]][pos[1:0]*8 +: 8] <= cmd.put_byte;
    if (cmd.put_len) begin
      buf_r[14] <= len_r[31:0];
      buf_r[15] <= len_r[63:32];
    end
  end

  // one round per cycle
  logic [31:0] f, sum, rot;
  logic [3:0]  g;
  logic [4:0]  s;
  always_comb begin
    unique case (rnd_r[5:4])
      2'd0: begin f = (b_r & c_r) | (~b_r & d_r); g = rnd_r[3:0]; end
      2'd1: begin f = (b_r & d_r) | (c_r & ~d_r); g = 4'(5 * rnd_r + 1); end
      2'd2: begin f = b_r ^ c_r ^ d_r;            g = 4'(3 * rnd_r + 5); end
      default: begin f = c_r ^ (b_r | ~d_r);      g = 4'(7 * rnd_r); end
    endcase
    s   = rot_amt(rnd_r);
    sum = a_r + f + k_const(rnd_r) + buf_r[g];
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  always_ff @(posedge clk) begin
    if (cmd.comp_start) begin
      a_r <= ch_r[0]; b_r <= ch_r[1]; c_r <= ch_r[2]; d_r <= ch_r[3];
    end else if (cmd.round) begin
      a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= b_r + rot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rnd_r <= '0;
    else if (cmd.comp_start) rnd_r <= '0;
    else if (cmd.round) rnd_r <= rnd_r + 6'd1;
  end

  // chaining words
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) begin
      ch_r[0] <= IV_A; ch_r[1] <= IV_B; ch_r[2] <= IV_C; ch_r[3] <= IV_D;
    end else if (cmd.fold) begin
      ch_r[0] <= ch_r[0] + a_r; ch_r[1] <= ch_r[1] + b_r;
      ch_r[2] <= ch_r[2] + c_r; ch_r[3] <= ch_r[3] + d_r;
    end
  end
endmodule

[sv/md5_digest_engine.sv]
// MD5 digest engine: byte-per-transaction input, four-word digest output.
// Data: a byte is taken while idle; the 64th byte of a block starts 64 rounds and a fold.
// Finish: pad bytes, then the length words, compression of each block, then 4 words.
// Throughput: one round unit, 1 round/cycle; no input is taken until a block is compressed.
// Reset: synchronous active low; chain words to initial values, bit count to zero.
// Top level; depends on md5_pkg, md5_ctrl, md5_dp and md5_digest_engine_assert.svh.
`timescale 1ns / 1ps
`include "md5_digest_engine_assert.svh"
module md5_digest_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [1:0]  out_tuser,  // [1:0] word_index
  output logic        out_tlast
);
  import md5_pkg::*;

  md5_cmd_t   cmd;
  md5_stat_t  stat;
  logic [1:0] idx;

  md5_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .req_type(in_tuser), .data_byte(in_tdata),
    .stat, .cmd, .out_tvalid, .out_tready, .out_idx(idx)
  );

  md5_dp u_dp (
    .clk, .rst_n, .cmd, .out_idx(idx), .stat, .digest_word(out_tdata)
  );

  assign out_tuser = idx;
  assign out_tlast = (idx == 2'd3);

  `MD5_ASSERT_IMPL(a_no_overlap, clk, rst_n, !(in_tready && out_tvalid),
    "input ready during output")
  `MD5_ASSERT_NEXT(a_out_order, clk, rst_n, out_tvalid && out_tready && !out_tlast,
    out_tvalid && out_tuser == $past(out_tuser) + 2'd1, "digest words out of order")
endmodule

[tb/md5_digest_checker.sv]
// Digest checker for the MD5 digest engine: watches both streams, predicts
// each digest word and compares it. Depends on md5_pkg for request codes and IVs.
`timescale 1ns / 1ps
module md5_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_words
);
  import md5_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        last;
  } digest_word_t;

  digest_word_t digest_q[$];
  logic [31:0] chain[4];
  logic [31:0] blk[16];
  logic [63:0] nbits;

  localparam logic [31:0] SINE_TAB[64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int SHIFT_TAB[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  assign pending_words = digest_q.size();

  task automatic reset_context();
    chain[0] = IV_A; chain[1] = IV_B; chain[2] = IV_C; chain[3] = IV_D;
    nbits = '0;
  endtask

  task automatic run_block();
    logic [31:0] a, b, c, d, f, t, s;
    int g, grp;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      grp = i / 16;
      case (grp)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      s = a + f + SINE_TAB[i] + blk[g];
      t = d; d = c; c = b;
      b = b + ((s << SHIFT_TAB[grp * 4 + i % 4]) | (s >> (32 - SHIFT_TAB[grp * 4 + i % 4])));
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic append_byte(input logic [7:0] v);
    logic [5:0] pos;
    pos = nbits[8:3];
    blk[pos[5:2]][pos[1:0]*8 +: 8] = v;
    nbits += 64'd8;
    if (pos == 6'd63) run_block();
  endtask

  task automatic finish_digest();
    logic [63:0] len;
    len = nbits;
    append_byte(PAD_BYTE);
    while (nbits[8:3] != LEN_POS) append_byte(8'h00);
    blk[14] = len[31:0];
    blk[15] = len[63:32];
    run_block();
    for (int k = 0; k < 4; k++) digest_q.push_back({chain[k], 2'(k), k == 3});
    reset_context();
  endtask

  initial begin
    fail_count = 0;
    reset_context();
    foreach (blk[i]) blk[i] = '0;
  end

  // Predict on accepted requests, check accepted digest words
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          REQ_DATA:    append_byte(in_tdata);
          REQ_FINISH:  finish_digest();
          REQ_RESTART: reset_context();
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (digest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected digest word %h idx %0d", out_tdata, out_tuser);
        end else begin
          digest_word_t e;
          e = digest_q.pop_front();
          if (e.word !== out_tdata || e.idx !== out_tuser || e.last !== out_tlast) begin
            fail_count++;
            if (fail_count <= 10)
              $display("digest word: exp %h/%0d/%0d got %h/%0d/%0d",
                       e.word, e.idx, e.last, out_tdata, out_tuser, out_tlast);
          end
        end
      end
    end
  end
endmodule

[tb/tb.sv]
// Testbench top for md5_digest_engine: drives request transactions and the
// output back-pressure, and reports the verdict. Depends on md5_pkg, md5_digest_checker.
`timescale 1ns / 1ps
module tb;
  import md5_pkg::*;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready;
  logic [7:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid, out_tready = 0, out_tlast;
  logic [31:0] out_tdata;
  logic [1:0] out_tuser;
  int fail_count, pending_words;
  int cycles = 0;
  bit hold_output = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  md5_digest_engine u_top (.*);

  md5_digest_checker u_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .fail_count, .pending_words);

  // Send one request; random gap first unless no_gap is set
  task automatic send_req(input logic [1:0] kind, input logic [7:0] v, input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    repeat (gap) @(negedge clk);
    in_tvalid = 1; in_tuser = kind; in_tdata = v;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 0;
  endtask

  task automatic send_message(input int n, input bit dense);
    for (int i = 0; i < n; i++) send_req(REQ_DATA, 8'($urandom), dense);
  endtask

  task automatic drain();
    while (pending_words != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // Receiver stall pattern, with one long hold-off on request
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_tready <= 0;
        repeat (400) @(negedge clk);
        hold_output = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("md5_digest_engine: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // Directed: empty message, ignored selector, restart, edge bytes
    send_req(REQ_FINISH, 8'hFF);
    send_req(2'd3, 8'hA5);
    send_req(REQ_DATA, 8'h00);
    send_req(REQ_DATA, 8'hFF);
    send_req(REQ_RESTART, 8'h5A);
    send_req(REQ_DATA, 8'h61);
    send_req(REQ_FINISH, 8'h00);
    drain();
    // Lengths around the padding boundaries
    send_message(55, 1'b1); send_req(REQ_FINISH, 8'h00);
    send_message(56, 1'b1); send_req(REQ_FINISH, 8'h00);
    send_message(64, 1'b1); send_req(REQ_FINISH, 8'h00);
    drain();
    // Long receiver hold-off; the sender waits on in_tready meanwhile
    hold_output = 1;
    for (int m = 0; m < 4; m++) begin
      send_message($urandom_range(0, 8), 1'b1);
      send_req(REQ_FINISH, 8'h00, 1'b1);
    end
    drain();
    // Random: mostly whole messages, some restarts and noise
    for (int m = 0; m < 10; m++) begin
      int len;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 6);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 19))
          0: send_req(REQ_RESTART, 8'($urandom));
          1: send_req(2'd3, 8'($urandom));
          default: send_req(REQ_DATA, 8'($urandom), 1'($urandom_range(0, 1)));
        endcase
      end
      send_req(REQ_FINISH, 8'($urandom));
      if (m % 5 == 4) drain();
    end
    drain();
    if (fail_count == 0) begin
      $display("md5_digest_engine: match");
    end else begin
      $display("md5_digest_engine: mismatch");
    end
    $finish;
  end
endmodule
